/* design/rtll_pkg.sv */
// ----------------------------------------------------------------------------
// rtll_pkg: shared types and constants of the ticket lock lanes
// Operation and status codes, register indexes, and the transaction
// structs that pass between the front end, the back end and the queues.
// ----------------------------------------------------------------------------
package rtll_pkg;

  // defaults for the top-level parameters
  localparam int NUM_LANES_DEF      = 8;
  localparam int TICKET_BITS_DEF    = 16;
  localparam int REQUESTER_BITS_DEF = 4;
  localparam int MAX_NEST_DEF       = 255;

  // port field widths
  localparam int MODE_W      = 2;
  localparam int LANE_IDX_W  = 3;
  localparam int REQ_ID_W    = 4;
  localparam int TICKET_W    = 16;
  localparam int STATUS_W    = 4;
  localparam int QDEPTH_W    = 16;
  localparam int SEQ_W       = 32;
  localparam int LIMIT_W     = 16;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [LIMIT_W-1:0] QUEUE_CAP_RESET = 16'd64;

  // register index, taken from the word address bit of paddr
  typedef enum logic [0:0] {
    REG_QUEUE_CAP = 1'b0,
    REG_UNMAPPED  = 1'b1
  } reg_idx_t;

  // mode field codes
  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POLL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // decoded operation
  typedef enum logic [1:0] {
    OP_ACQUIRE,
    OP_POLL,
    OP_RELEASE,
    OP_NONE
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED        = 4'd0,
    ST_REENTRANT      = 4'd1,
    ST_ENQUEUED       = 4'd2,
    ST_WAIT           = 4'd3,
    ST_BACKPRESSURE   = 4'd4,
    ST_OVERFLOW       = 4'd5,
    ST_NEST_OVERFLOW  = 4'd6,
    ST_RELEASED       = 4'd7,
    ST_NESTED_RELEASE = 4'd8,
    ST_OWNER_MISMATCH = 4'd9
  } status_t;

  // classified request from the front end
  typedef struct packed {
    op_t                   op;
    logic                  lane_ok;
    logic [LANE_IDX_W-1:0] lane_index;
    logic [REQ_ID_W-1:0]   requester_id;
    logic [TICKET_W-1:0]   ticket;
  } cmd_t;

  // result transaction from the back end
  typedef struct packed {
    status_t             status;
    logic [TICKET_W-1:0] ticket_out;
    logic [QDEPTH_W-1:0] queue_depth;
    logic [SEQ_W-1:0]    sequence_res;
    logic                ticket_skew;
  } res_t;

endpackage

/* design/rtll_fifo.sv */
// ----------------------------------------------------------------------------
// rtll_fifo: small register fifo
// Flop-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module rtll_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = data_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= din_i;
    end
  end

endmodule

/* design/rtll_front.sv */
// ----------------------------------------------------------------------------
// rtll_front: request intake and classification
// Decodes the mode, checks the lane range and queues the request for the
// back end.
// ----------------------------------------------------------------------------
module rtll_front #(
  parameter int NUM_LANES = rtll_pkg::NUM_LANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [rtll_pkg::MODE_W-1:0]     in_mode,
  input  logic [rtll_pkg::LANE_IDX_W-1:0] in_lane_index,
  input  logic [rtll_pkg::REQ_ID_W-1:0]   in_requester_id,
  input  logic [rtll_pkg::TICKET_W-1:0]   in_ticket,
  output logic                            cmd_valid_o,
  output rtll_pkg::cmd_t                  cmd_o,
  input  logic                            cmd_take_i
);

  import rtll_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  // classify the incoming transaction
  always_comb begin
    cmd_in.lane_ok      = (32'(in_lane_index) < NUM_LANES);
    cmd_in.lane_index   = in_lane_index;
    cmd_in.requester_id = in_requester_id;
    cmd_in.ticket       = in_ticket;
    unique case (in_mode)
      MODE_ACQUIRE: cmd_in.op = OP_ACQUIRE;
      MODE_POLL:    cmd_in.op = OP_POLL;
      MODE_RELEASE: cmd_in.op = OP_RELEASE;
      default:      cmd_in.op = OP_NONE;
    endcase
  end

  // command queue toward the back end
  rtll_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .din_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_take_i),
    .dout_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

/* design/rtll_back.sv */
// ----------------------------------------------------------------------------
// rtll_back: lane state and request execution
// Holds the per-lane ticket lock state and the global grant sequence
// counter, and performs one read-modify-write of a lane per in-range request.
// ----------------------------------------------------------------------------
module rtll_back #(
  parameter int NUM_LANES      = rtll_pkg::NUM_LANES_DEF,
  parameter int TICKET_BITS    = rtll_pkg::TICKET_BITS_DEF,
  parameter int REQUESTER_BITS = rtll_pkg::REQUESTER_BITS_DEF,
  parameter int MAX_NEST       = rtll_pkg::MAX_NEST_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rtll_pkg::LIMIT_W-1:0] queue_cap_i,
  input  logic                         cmd_valid_i,
  input  rtll_pkg::cmd_t               cmd_i,
  output logic                         cmd_take_o,
  output logic                         res_push_o,
  output rtll_pkg::res_t               res_o,
  input  logic                         res_full_i
);

  import rtll_pkg::*;

  localparam int LANE_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int CMP_W  = (TICKET_BITS > LIMIT_W) ? TICKET_BITS : LIMIT_W;

  // per-lane state
  logic [TICKET_BITS-1:0]    next_ticket_r    [NUM_LANES];
  logic [TICKET_BITS-1:0]    serving_ticket_r [NUM_LANES];
  logic [TICKET_BITS-1:0]    active_ticket_r  [NUM_LANES];
  logic [REQUESTER_BITS-1:0] owner_id_r       [NUM_LANES];
  logic [NEST_W-1:0]         owner_depth_r    [NUM_LANES];
  logic [SEQ_W-1:0]          seq_r, seq_nxt;

  logic [LANE_W-1:0]         lane;
  logic [REQUESTER_BITS-1:0] req;
  logic [TICKET_BITS-1:0]    tk;
  logic [TICKET_BITS-1:0]    cur_nt, cur_st, cur_act;
  logic [REQUESTER_BITS-1:0] cur_own;
  logic [NEST_W-1:0]         cur_dep;
  logic [TICKET_BITS-1:0]    nt_nxt, st_nxt, act_nxt;
  logic [REQUESTER_BITS-1:0] own_nxt;
  logic [NEST_W-1:0]         dep_nxt;
  logic [TICKET_BITS-1:0]    depth_cur, depth_new, tout;
  logic [SEQ_W-1:0]          seq_val;
  logic                      seq_take, viol, do_step;
  status_t                   status;

  assign cmd_take_o = cmd_valid_i && !res_full_i;
  assign res_push_o = cmd_take_o;
  assign do_step    = cmd_take_o && cmd_i.lane_ok;

  // execute one request against the addressed lane
  always_comb begin
    lane    = LANE_W'(cmd_i.lane_index);
    req     = REQUESTER_BITS'(cmd_i.requester_id);
    tk      = TICKET_BITS'(cmd_i.ticket);
    cur_nt  = next_ticket_r[lane];
    cur_st  = serving_ticket_r[lane];
    cur_act = active_ticket_r[lane];
    cur_own = owner_id_r[lane];
    cur_dep = owner_depth_r[lane];
    nt_nxt  = cur_nt;
    st_nxt  = cur_st;
    act_nxt = cur_act;
    own_nxt = cur_own;
    dep_nxt = cur_dep;
    status  = ST_WAIT;
    tout    = '0;
    viol    = 1'b0;
    seq_take = 1'b0;
    depth_cur = (cur_nt < cur_st) ? '0 : cur_nt - cur_st;

    // sequence draw, zero is skipped on wrap
    seq_val = (seq_r == '0) ? SEQ_W'(1) : seq_r;
    seq_nxt = (seq_r == '0) ? SEQ_W'(2) : seq_r + 1'b1;

    if (cmd_i.lane_ok) begin
      unique case (cmd_i.op)
        OP_ACQUIRE: begin
          if (cur_dep != '0 && cur_own == req) begin
            if (cur_dep >= NEST_W'(MAX_NEST)) begin
              status = ST_NEST_OVERFLOW;
            end else begin
              dep_nxt  = cur_dep + 1'b1;
              act_nxt  = (cur_act == '0) ? cur_st : cur_act;
              tout     = act_nxt;
              seq_take = 1'b1;
              status   = ST_REENTRANT;
            end
          end else if (CMP_W'(depth_cur) >= CMP_W'(queue_cap_i)) begin
            status = ST_BACKPRESSURE;
          end else begin
            nt_nxt = cur_nt + 1'b1;
            if (cur_nt == '0) begin
              status = ST_OVERFLOW;
            end else if (cur_nt == cur_st && cur_dep == '0) begin
              own_nxt  = req;
              dep_nxt  = NEST_W'(1);
              act_nxt  = cur_nt;
              tout     = cur_nt;
              seq_take = 1'b1;
              status   = ST_GRANTED;
            end else begin
              tout   = cur_nt;
              status = ST_ENQUEUED;
            end
          end
        end
        OP_POLL: begin
          if (cur_dep == '0 && tk == cur_st && cur_st < cur_nt) begin
            own_nxt  = req;
            dep_nxt  = NEST_W'(1);
            act_nxt  = tk;
            tout     = tk;
            seq_take = 1'b1;
            status   = ST_GRANTED;
          end
        end
        OP_RELEASE: begin
          if (cur_dep == '0 || cur_own != req) begin
            status = ST_OWNER_MISMATCH;
          end else begin
            dep_nxt = cur_dep - 1'b1;
            if (cur_dep == NEST_W'(1)) begin
              viol    = (cur_st != tk);
              st_nxt  = (cur_st < cur_nt) ? cur_st + 1'b1 : cur_st;
              own_nxt = '0;
              act_nxt = '0;
              status  = ST_RELEASED;
            end else begin
              status = ST_NESTED_RELEASE;
            end
          end
        end
        default: begin
          status = ST_WAIT;
        end
      endcase
    end

    depth_new = (nt_nxt < st_nxt) ? '0 : nt_nxt - st_nxt;

    // result transaction
    res_o.status       = status;
    res_o.ticket_out   = TICKET_W'(tout);
    res_o.queue_depth  = cmd_i.lane_ok ? QDEPTH_W'(depth_new) : '0;
    res_o.sequence_res = seq_take ? seq_val : '0;
    res_o.ticket_skew  = viol;
  end

  // lane state write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        next_ticket_r[i]    <= TICKET_BITS'(1);
        serving_ticket_r[i] <= TICKET_BITS'(1);
        active_ticket_r[i]  <= '0;
        owner_id_r[i]       <= '0;
        owner_depth_r[i]    <= '0;
      end
      seq_r <= SEQ_W'(1);
    end else if (do_step) begin
      next_ticket_r[lane]    <= nt_nxt;
      serving_ticket_r[lane] <= st_nxt;
      active_ticket_r[lane]  <= act_nxt;
      owner_id_r[lane]       <= own_nxt;
      owner_depth_r[lane]    <= dep_nxt;
      if (seq_take) begin
        seq_r <= seq_nxt;
      end
    end
  end

endmodule

/* design/reentrant_ticket_lock_lanes.sv */
// ----------------------------------------------------------------------------
// reentrant_ticket_lock_lanes: multi-lane re-entrant ticket lock unit
// Each lane is a bounded ticket lock that its owner may re-enter. Requests
// (acquire, poll, release) enter through a push/full queue and each gives
// exactly one result on the empty/pop side. A front end decodes and queues
// requests; a back end holds all lane state in registers and carries out
// one request per clock while the result queue is not full, as a single
// read-modify-write of the addressed lane, so the unit then sustains one
// request per cycle. Requests and results are registered in the two queues.
// Two-entry queues on both sides let either neighbor stall without stopping
// the other. The queue cap register (byte address 0) sets the queue depth at
// which new acquires are refused; write it only while no request is in
// flight.
// ----------------------------------------------------------------------------
module reentrant_ticket_lock_lanes #(
  parameter int NUM_LANES      = rtll_pkg::NUM_LANES_DEF,
  parameter int TICKET_BITS    = rtll_pkg::TICKET_BITS_DEF,
  parameter int REQUESTER_BITS = rtll_pkg::REQUESTER_BITS_DEF,
  parameter int MAX_NEST       = rtll_pkg::MAX_NEST_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request side
  input  logic                            push,
  output logic                            full,
  input  logic [rtll_pkg::MODE_W-1:0]     in_mode,
  input  logic [rtll_pkg::LANE_IDX_W-1:0] in_lane_index,
  input  logic [rtll_pkg::REQ_ID_W-1:0]   in_requester_id,
  input  logic [rtll_pkg::TICKET_W-1:0]   in_ticket,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic [rtll_pkg::STATUS_W-1:0]   out_status,
  output logic [rtll_pkg::TICKET_W-1:0]   out_ticket_out,
  output logic [rtll_pkg::QDEPTH_W-1:0]   out_queue_depth,
  output logic [rtll_pkg::SEQ_W-1:0]      out_sequence_res,
  output logic                            out_ticket_skew,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rtll_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rtll_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rtll_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  import rtll_pkg::*;

  logic [LIMIT_W-1:0] queue_cap_r;
  reg_idx_t           reg_sel;
  cmd_t               cmd;
  logic               cmd_valid, cmd_take;
  res_t               res_in, res_out;
  logic               res_push, res_full;

  // register access
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_cap_r <= QUEUE_CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel == REG_QUEUE_CAP) begin
      queue_cap_r <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_QUEUE_CAP: prdata = CFG_DATA_W'(queue_cap_r);
      default:       prdata = '0;
    endcase
  end

  rtll_front #(
    .NUM_LANES (NUM_LANES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_mode         (in_mode),
    .in_lane_index   (in_lane_index),
    .in_requester_id (in_requester_id),
    .in_ticket       (in_ticket),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_take_i      (cmd_take)
  );

  rtll_back #(
    .NUM_LANES      (NUM_LANES),
    .TICKET_BITS    (TICKET_BITS),
    .REQUESTER_BITS (REQUESTER_BITS),
    .MAX_NEST       (MAX_NEST)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_cap_i (queue_cap_r),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // result queue toward the consumer
  rtll_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .din_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .dout_o  (res_out),
    .empty_o (empty)
  );

  assign out_status       = res_out.status;
  assign out_ticket_out   = res_out.ticket_out;
  assign out_queue_depth  = res_out.queue_depth;
  assign out_sequence_res = res_out.sequence_res;
  assign out_ticket_skew  = res_out.ticket_skew;

endmodule

/* design/rtll_checker.sv */
// ----------------------------------------------------------------------------
// rtll_checker: port-level assertions for the ticket lock lanes
// Watches the result side of the top level and is bound to it.
// ----------------------------------------------------------------------------
module rtll_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          empty,
  input logic                          pop,
  input logic [rtll_pkg::STATUS_W-1:0] out_status,
  input logic [rtll_pkg::SEQ_W-1:0]    out_sequence_res,
  input logic                          out_ticket_skew
);

  import rtll_pkg::*;

  logic is_grant;

  assign is_grant = (out_status == ST_GRANTED) || (out_status == ST_REENTRANT);

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) && $stable(out_sequence_res)))
    else $error("result changed before it was popped");

  // grants always carry a nonzero sequence number
  a_grant_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && is_grant) |-> (out_sequence_res != '0))
    else $error("grant without sequence number");

  // non-grants never carry a sequence number
  a_nogrant_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !is_grant) |-> (out_sequence_res == '0))
    else $error("sequence number on a non-grant result");

  // ticket skew is only reported on a top-level release
  a_viol: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_ticket_skew) |-> (out_status == ST_RELEASED))
    else $error("ticket skew outside a release");

endmodule

bind reentrant_ticket_lock_lanes rtll_checker u_rtll_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .empty            (empty),
  .pop              (pop),
  .out_status       (out_status),
  .out_sequence_res (out_sequence_res),
  .out_ticket_skew  (out_ticket_skew)
);
